// ===== src/ipv4rx_pkg.sv =====
// shared types, constants and a helper function for the ipv4 receive header check
package ipv4rx_pkg;

    localparam int WORD_W     = 16;
    localparam int INDEX_W    = 4;
    localparam int ADDR_W     = 32;
    localparam int HBYTES_W   = 6;
    localparam int PROTO_W    = 8;
    localparam int VERDICT_W  = 3;

    // word positions inside the fixed header
    localparam logic [INDEX_W-1:0] IDX_VERSION      = 4'd0;
    localparam logic [INDEX_W-1:0] IDX_TOTAL_LENGTH = 4'd1;
    localparam logic [INDEX_W-1:0] IDX_PROTOCOL     = 4'd4;
    localparam logic [INDEX_W-1:0] IDX_CHECKSUM     = 4'd5;
    localparam logic [INDEX_W-1:0] IDX_DEST_HIGH    = 4'd8;
    localparam logic [INDEX_W-1:0] IDX_LAST         = 4'd9;
    localparam logic [INDEX_W-1:0] WORDS_PER_HEADER = 4'd10;

    localparam logic [HBYTES_W-1:0] MIN_HEADER_BYTES    = 6'd20;
    localparam logic [ADDR_W-1:0]   BROADCAST_ADDR      = 32'hFFFF_FFFF;
    localparam logic [ADDR_W-1:0]   LOCAL_ADDRESS_RESET = 32'hC0A8_0001;

    localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
    localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_ICMP         = 3'd0,
        VERDICT_TCP          = 3'd1,
        VERDICT_UDP          = 3'd2,
        VERDICT_OTHER        = 3'd3,
        VERDICT_BAD_CHECKSUM = 3'd4,
        VERDICT_BAD_LENGTH   = 3'd5,
        VERDICT_NOT_FOR_US   = 3'd6
    } verdict_t;

    // header fields gathered by the accumulator, valid with its done flag
    typedef struct packed {
        logic [WORD_W-1:0]  sum;
        logic [WORD_W-1:0]  checksum;
        logic [3:0]         ihl;
        logic [WORD_W-1:0]  total_length;
        logic [PROTO_W-1:0] protocol;
        logic [ADDR_W-1:0]  dest;
    } hdr_fields_t;

    // end-around carry add of two 16-bit words
    function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage

// ===== src/ipv4rx_if.sv =====
// handshake channels: header words in, check results out, configuration writes

interface ipv4rx_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] header_word;
    logic        first_word;

    modport source (output valid, output header_word, output first_word, input ready);
    modport sink   (input valid, input header_word, input first_word, output ready);
endinterface

interface ipv4rx_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [15:0] payload_length;
    logic [5:0]  header_bytes;
    logic [7:0]  protocol_number;
    logic        broadcast;

    modport source (output valid, output verdict, output payload_length,
                    output header_bytes, output protocol_number, output broadcast,
                    input ready);
    modport sink   (input valid, input verdict, input payload_length,
                    input header_bytes, input protocol_number, input broadcast,
                    output ready);
endinterface

interface ipv4rx_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] local_address;

    modport source (output valid, output local_address, input ready);
    modport sink   (input valid, input local_address, output ready);
endinterface

// ===== src/ipv4_receive_header_check.sv =====
// top level: ipv4 header check, input register, accumulator, verdict and result register
// the tenth header word's result goes from the input register into the result register
// throughput: one header word per cycle unless stalled, bounded by the 16-bit end-around
// add of the sum; a stalled result is held in the result register while the input
// register keeps taking beats up to the next tenth word; reset (rst_n, async, active
// low) clears count, sum, captures and valids; local address returns to 192.168.0.1
module ipv4_receive_header_check (
    input  logic                   clk,
    input  logic                   rst_n,
    ipv4rx_word_if.sink            hdr,
    ipv4rx_result_if.source        result,
    ipv4rx_cfg_if.sink             cfg
);
    import ipv4rx_pkg::*;

    // configuration register, always writable
    logic [ADDR_W-1:0] local_address_reg;

    // input register stage
    logic              in_valid_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              in_first_reg;

    // result register stage
    logic                out_valid_reg,   out_valid_next;
    verdict_t            verdict_reg,     verdict_next;
    logic [WORD_W-1:0]   plen_reg,        plen_next;
    logic [HBYTES_W-1:0] hbytes_reg,      hbytes_next;
    logic [PROTO_W-1:0]  proto_reg,       proto_next;
    logic                bcast_reg,       bcast_next;

    logic        done;
    hdr_fields_t fields;
    logic        out_free;
    logic        advance;

    // the input register moves on unless it holds a finishing beat and the
    // result register is still occupied
    assign out_free  = !out_valid_reg || result.ready;
    assign advance   = in_valid_reg && (!done || out_free);
    assign hdr.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    ipv4rx_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .header_word (in_word_reg),
        .first_word  (in_first_reg),
        .done        (done),
        .fields      (fields)
    );

    // verdict: checksum first, then header length, then destination, then protocol
    always_comb
    begin
        hbytes_next = {fields.ihl, 2'b00};
        plen_next   = fields.total_length - {{(WORD_W-HBYTES_W){1'b0}}, hbytes_next};
        proto_next  = fields.protocol;
        bcast_next  = (fields.dest == BROADCAST_ADDR);

        if (~fields.sum != fields.checksum)
            verdict_next = VERDICT_BAD_CHECKSUM;
        else if (hbytes_next < MIN_HEADER_BYTES)
            verdict_next = VERDICT_BAD_LENGTH;
        else if (fields.dest != local_address_reg && !bcast_next)
            verdict_next = VERDICT_NOT_FOR_US;
        else if (fields.protocol == PROTO_ICMP)
            verdict_next = VERDICT_ICMP;
        else if (fields.protocol == PROTO_TCP)
            verdict_next = VERDICT_TCP;
        else if (fields.protocol == PROTO_UDP)
            verdict_next = VERDICT_UDP;
        else
            verdict_next = VERDICT_OTHER;

        // load on a finishing beat, drop once the consumer takes the result
        if (advance && done)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= LOCAL_ADDRESS_RESET;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                local_address_reg <= cfg.local_address;
            if (hdr.ready)
                in_valid_reg <= hdr.valid;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (hdr.valid && hdr.ready)
        begin
            in_word_reg  <= hdr.header_word;
            in_first_reg <= hdr.first_word;
        end
        if (advance && done)
        begin
            verdict_reg <= verdict_next;
            plen_reg    <= plen_next;
            hbytes_reg  <= hbytes_next;
            proto_reg   <= proto_next;
            bcast_reg   <= bcast_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.verdict         = verdict_reg;
    assign result.payload_length  = plen_reg;
    assign result.header_bytes    = hbytes_reg;
    assign result.protocol_number = proto_reg;
    assign result.broadcast       = bcast_reg;

    // a finishing beat always lands in the result register
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        advance && done |=> out_valid_reg)
        else $error("finished header did not produce a result");

    // verdict codes stay within the defined set
    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (verdict_reg <= VERDICT_NOT_FOR_US))
        else $error("verdict code out of range");

    // a protocol class is only given to headers of legal length
    a_class_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (verdict_reg <= VERDICT_OTHER) |-> (hbytes_reg >= MIN_HEADER_BYTES))
        else $error("classified header with short length");

    // a finishing beat never advances over an unconsumed result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !(advance && done))
        else $error("result overwritten before it was taken");

endmodule

// ===== src/ipv4rx_accum.sv =====
// word counter, running ones' complement sum and header field capture
module ipv4rx_accum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic [15:0]                 header_word,
    input  logic                        first_word,
    output logic                        done,
    output ipv4rx_pkg::hdr_fields_t     fields
);
    import ipv4rx_pkg::*;

    logic [INDEX_W-1:0] index_reg,    index_next;
    logic [WORD_W-1:0]  sum_reg,      sum_next;
    logic [WORD_W-1:0]  checksum_reg, checksum_next;
    logic [3:0]         ihl_reg,      ihl_next;
    logic [WORD_W-1:0]  length_reg,   length_next;
    logic [PROTO_W-1:0] proto_reg,    proto_next;
    logic [WORD_W-1:0]  dest_hi_reg,  dest_hi_next;

    logic [INDEX_W-1:0] eff_index;
    logic [WORD_W-1:0]  eff_sum;
    logic [WORD_W-1:0]  sum_add;
    logic               active;

    always_comb
    begin
        // a first-word beat restarts the count and the sum
        eff_index = first_word ? '0 : index_reg;
        eff_sum   = first_word ? '0 : sum_reg;
        active    = (eff_index < WORDS_PER_HEADER);
        sum_add   = ones_add(eff_sum, header_word);

        index_next    = index_reg;
        sum_next      = sum_reg;
        checksum_next = checksum_reg;
        ihl_next      = ihl_reg;
        length_next   = length_reg;
        proto_next    = proto_reg;
        dest_hi_next  = dest_hi_reg;

        if (fire)
        begin
            index_next = eff_index;
            sum_next   = eff_sum;
            if (active)
            begin
                index_next = eff_index + 4'd1;
                if (eff_index == IDX_CHECKSUM)
                    checksum_next = header_word;
                else
                    sum_next = sum_add;
                case (eff_index)
                    IDX_VERSION:      ihl_next     = header_word[11:8];
                    IDX_TOTAL_LENGTH: length_next  = header_word;
                    IDX_PROTOCOL:     proto_next   = header_word[7:0];
                    IDX_DEST_HIGH:    dest_hi_next = header_word;
                    default:          ;
                endcase
            end
        end

        done                = active && (eff_index == IDX_LAST);
        fields.sum          = sum_add;
        fields.checksum     = checksum_reg;
        fields.ihl          = ihl_reg;
        fields.total_length = length_reg;
        fields.protocol     = proto_reg;
        fields.dest         = {dest_hi_reg, header_word};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg    <= '0;
            sum_reg      <= '0;
            checksum_reg <= '0;
            ihl_reg      <= '0;
            length_reg   <= '0;
            proto_reg    <= '0;
            dest_hi_reg  <= '0;
        end
        else
        begin
            index_reg    <= index_next;
            sum_reg      <= sum_next;
            checksum_reg <= checksum_next;
            ihl_reg      <= ihl_next;
            length_reg   <= length_next;
            proto_reg    <= proto_next;
            dest_hi_reg  <= dest_hi_next;
        end
    end

endmodule
